### rtl/sha_pkg.sv
// SHA-256 constants, round functions and control types.
package sha_pkg;

    localparam int unsigned WORD_W = 32;

    typedef logic [31:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       init_hash;
        logic       write_byte;
        logic [7:0] wr_data;
        logic [5:0] wr_addr;
        logic       start_block;
        logic       round_step;
        logic [5:0] round_idx;
        logic       fold;
        logic [2:0] out_idx;
    } dp_cmd_t;

    localparam word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic word_t round_k(input logic [5:0] i);
        word_t k;
        case (i)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

endpackage

### rtl/sha_if.sv
// Valid/ready channel interfaces for input bytes and digest words.
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

### rtl/sha_datapath.sv
// SHA-256 datapath: block buffer, message schedule, round registers, hash words.
module sha_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  sha_pkg::dp_cmd_t cmd,
    output sha_pkg::word_t   hash_word
);

    sha_pkg::word_t blk_reg [16];
    sha_pkg::word_t w_reg [16];
    sha_pkg::word_t v_reg [8];
    sha_pkg::word_t h_reg [8];

    sha_pkg::word_t w_new;
    sha_pkg::word_t w_cur;
    sha_pkg::word_t t1;
    sha_pkg::word_t t2;
    sha_pkg::word_t s0;
    sha_pkg::word_t s1;

    always_comb
    begin
        s0 = sha_pkg::rotr(w_reg[1], 7) ^ sha_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = sha_pkg::rotr(w_reg[14], 17) ^ sha_pkg::rotr(w_reg[14], 19)
             ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        w_cur = (cmd.round_idx < 6'd16) ? w_reg[0] : w_new;
        t1 = v_reg[7]
             + (sha_pkg::rotr(v_reg[4], 6) ^ sha_pkg::rotr(v_reg[4], 11)
                ^ sha_pkg::rotr(v_reg[4], 25))
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + sha_pkg::round_k(cmd.round_idx) + w_cur;
        t2 = (sha_pkg::rotr(v_reg[0], 2) ^ sha_pkg::rotr(v_reg[0], 13)
              ^ sha_pkg::rotr(v_reg[0], 22))
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // byte buffer, big-endian within words
    always_ff @(posedge clk)
    begin
        if (cmd.write_byte)
        begin
            case (cmd.wr_addr[1:0])
                2'd0:    blk_reg[cmd.wr_addr[5:2]][31:24] <= cmd.wr_data;
                2'd1:    blk_reg[cmd.wr_addr[5:2]][23:16] <= cmd.wr_data;
                2'd2:    blk_reg[cmd.wr_addr[5:2]][15:8]  <= cmd.wr_data;
                default: blk_reg[cmd.wr_addr[5:2]][7:0]   <= cmd.wr_data;
            endcase
        end
    end

    // schedule window and working variables
    always_ff @(posedge clk)
    begin
        if (cmd.start_block)
        begin
            w_reg <= blk_reg;
            v_reg <= h_reg;
        end
        else if (cmd.round_step)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_cur;
            for (int i = 7; i > 0; i--)
                v_reg[i] <= v_reg[i - 1];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_reg <= sha_pkg::INIT_HASH;
        else if (cmd.init_hash)
            h_reg <= sha_pkg::INIT_HASH;
        else if (cmd.fold)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= h_reg[i] + v_reg[i];
        end
    end

    assign hash_word = h_reg[cmd.out_idx];

endmodule

### rtl/sha_control.sv
// SHA-256 controller: byte intake, padding sequence, rounds and digest output.
module sha_control (
    input  logic             clk,
    input  logic             rst_n,
    sha_in_if.sink           in_ch,
    output sha_pkg::dp_cmd_t cmd,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       out_idx
);

    sha_pkg::state_t state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  idx_reg, idx_next;
    logic        fin_reg, fin_next;  // message ending: pad after compression
    logic        pad_reg, pad_next;  // 0x80 byte placed
    logic        len_reg, len_next;  // length goes in the current block
    logic [63:0] lenc_reg, lenc_next;
    logic [63:0] bits_inc;

    assign bits_inc = bits_reg + 64'd8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha_pkg::ST_IDLE;
            fill_reg  <= '0;
            bits_reg  <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
            pad_reg   <= 1'b0;
            len_reg   <= 1'b0;
            lenc_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
            pad_reg   <= pad_next;
            len_reg   <= len_next;
            lenc_reg  <= lenc_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        fin_next   = fin_reg;
        pad_next   = pad_reg;
        len_next   = len_reg;
        lenc_next  = lenc_reg;
        cmd        = '0;
        cmd.out_idx   = idx_reg;
        cmd.round_idx = rnd_reg;
        in_ch.ready = 1'b0;
        out_valid   = 1'b0;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    if (in_ch.byte_present)
                    begin
                        cmd.write_byte = 1'b1;
                        cmd.wr_addr    = fill_reg;
                        cmd.wr_data    = in_ch.data_byte;
                        fill_next      = fill_reg + 6'd1;
                        bits_next      = bits_inc;
                    end
                    if (in_ch.end_of_message)
                    begin
                        fin_next  = 1'b1;
                        lenc_next = in_ch.byte_present ? bits_inc : bits_reg;
                    end
                    if (in_ch.byte_present && fill_reg == 6'd63)
                        state_next = sha_pkg::ST_LOAD;
                    else if (in_ch.end_of_message)
                        state_next = sha_pkg::ST_PAD;
                end
            end
            sha_pkg::ST_PAD:
            begin
                // write one pad byte a cycle from fill_reg up to the block end
                cmd.write_byte = 1'b1;
                cmd.wr_addr    = fill_reg;
                if (!pad_reg)
                begin
                    cmd.wr_data = sha_pkg::PAD_BYTE;
                    pad_next    = 1'b1;
                    len_next    = (fill_reg < sha_pkg::LEN_POS);
                end
                else if (len_reg && fill_reg >= sha_pkg::LEN_POS)
                    cmd.wr_data = lenc_reg[6'd63 - {fill_reg[2:0], 3'd0} -: 8];
                else
                    cmd.wr_data = 8'h00;
                fill_next = fill_reg + 6'd1;
                if (fill_reg == 6'd63)
                    state_next = sha_pkg::ST_LOAD;
            end
            sha_pkg::ST_LOAD:
            begin
                cmd.start_block = 1'b1;
                rnd_next   = '0;
                state_next = sha_pkg::ST_ROUND;
            end
            sha_pkg::ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                    state_next = sha_pkg::ST_FOLD;
            end
            sha_pkg::ST_FOLD:
            begin
                cmd.fold = 1'b1;
                fill_next = '0;
                if (!fin_reg)
                    state_next = sha_pkg::ST_IDLE;
                else if (!len_reg)
                begin
                    state_next = sha_pkg::ST_PAD;
                    len_next   = pad_reg;
                end
                else
                begin
                    state_next = sha_pkg::ST_EMIT;
                    idx_next   = '0;
                end
            end
            sha_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.init_hash = 1'b1;
                        state_next = sha_pkg::ST_IDLE;
                        fin_next   = 1'b0;
                        pad_next   = 1'b0;
                        len_next   = 1'b0;
                        bits_next  = '0;
                        fill_next  = '0;
                    end
                end
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    assign out_idx = idx_reg;

    property p_emit_only_when_final;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (fin_reg && len_reg);
    endproperty
    a_emit_final: assert property (p_emit_only_when_final)
        else $error("digest emitted outside a finished message");

    a_no_intake_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sha_pkg::ST_IDLE) |-> !in_ch.ready)
        else $error("input accepted while busy");

    a_round_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha_pkg::ST_ROUND && rnd_reg == 6'd63)
        |=> state_reg == sha_pkg::ST_FOLD)
        else $error("round count did not end compression");

endmodule

### rtl/sha256_stream_hasher.sv
// SHA-256 streaming hasher top level.
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   data_byte, byte_present, end_of_message
//  out_ch   out  valid/ready   digest_word, word_index, last_word
// Bytes are taken while idle; the 64th byte of a block holds intake for the
// load state, 64 one-per-cycle rounds and the fold state. An end item pads
// one byte a cycle to the block end, then compresses; a second pad block
// follows when the 0x80 byte lands at byte 56 or later. An end item that
// fills the block has it compressed first, then one pad block. Eight digest
// words follow, one per accepted cycle; out_ch stalls hold the current word.
// rst_n loads the initial hash values and clears counts; input is not taken
// until the digest is delivered.
module sha256_stream_hasher (
    input logic      clk,
    input logic      rst_n,
    sha_in_if.sink   in_ch,
    sha_out_if.source out_ch
);

    sha_pkg::dp_cmd_t cmd;
    sha_pkg::word_t   hash_word;
    logic             ovalid;
    logic [2:0]       oidx;

    sha_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd       (cmd),
        .out_valid (ovalid),
        .out_ready (out_ch.ready),
        .out_idx   (oidx)
    );

    sha_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .hash_word (hash_word)
    );

    assign out_ch.valid       = ovalid;
    assign out_ch.digest_word = hash_word;
    assign out_ch.word_index  = oidx;
    assign out_ch.last_word   = (oidx == 3'd7);

endmodule

### tb/sha256_stream_hasher_checker.sv
`timescale 1ns / 1ps
// Checker: watches both channels, predicts SHA-256 digests and compares them.
module sha256_stream_hasher_checker (
    input  logic      clk,
    input  logic      rst_n,
    sha_in_if         in_ch,
    sha_out_if        out_ch,
    output int        fail_count,
    output int        pending_words
);

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [31:0]  hash_state [8];
    logic [7:0]   block_buf [64];
    logic [5:0]   fill;
    logic [63:0]  bit_len;
    digest_item_t digest_queue [$];

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
        for (int t = 16; t < 64; t++)
        begin
            s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
            s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        for (int i = 0; i < 8; i++)
            v[i] = hash_state[i];
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
    endtask

    task automatic clear_message();
        for (int i = 0; i < 8; i++)
            hash_state[i] = sha_pkg::INIT_HASH[i];
        fill = '0;
        bit_len = '0;
    endtask

    task automatic absorb_item(input logic [7:0] b, input logic present, input logic fin);
        int pos;
        digest_item_t d;
        if (present)
        begin
            block_buf[fill] = b;
            bit_len += 64'd8;
            fill = fill + 6'd1;
            if (fill == 6'd0)
                compress();
        end
        if (!fin)
            return;
        pos = int'(fill);
        block_buf[pos] = sha_pkg::PAD_BYTE;
        pos = pos + 1;
        if (pos > int'(sha_pkg::LEN_POS))
        begin
            while (pos < 64)
            begin
                block_buf[pos] = 8'h00;
                pos = pos + 1;
            end
            compress();
            pos = 0;
        end
        while (pos < int'(sha_pkg::LEN_POS))
        begin
            block_buf[pos] = 8'h00;
            pos = pos + 1;
        end
        for (int i = 0; i < 8; i++)
            block_buf[56+i] = bit_len[63-8*i -: 8];
        compress();
        for (int i = 0; i < 8; i++)
        begin
            d.digest_word = hash_state[i];
            d.word_index = 3'(i);
            d.last_word = (i == 7);
            digest_queue.push_back(d);
        end
        clear_message();
    endtask

    always @(posedge clk)
    begin
        digest_item_t e;
        if (!rst_n)
        begin
            fail_count = 0;
            digest_queue.delete();
            clear_message();
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                absorb_item(in_ch.data_byte, in_ch.byte_present, in_ch.end_of_message);
            if (out_ch.valid && out_ch.ready)
            begin
                if (digest_queue.size() == 0)
                begin
                    $error("unexpected digest word %h", out_ch.digest_word);
                    fail_count++;
                end
                else
                begin
                    e = digest_queue.pop_front();
                    if (out_ch.digest_word !== e.digest_word)
                    begin
                        $error("digest_word expected %h actual %h", e.digest_word,
                               out_ch.digest_word);
                        fail_count++;
                    end
                    if (out_ch.word_index !== e.word_index)
                    begin
                        $error("word_index expected %0d actual %0d", e.word_index,
                               out_ch.word_index);
                        fail_count++;
                    end
                    if (out_ch.last_word !== e.last_word)
                    begin
                        $error("last_word expected %0d actual %0d", e.last_word,
                               out_ch.last_word);
                        fail_count++;
                    end
                end
            end
        end
        pending_words = digest_queue.size();
    end
endmodule

### tb/sha256_stream_hasher_test.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, byte stream stimulus and the verdict.
module sha256_stream_hasher_test;
    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_words;
    int   item_count;
    bit   quiet;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_stream_hasher u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    sha256_stream_hasher_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic send_item(input logic [7:0] b, input logic present, input logic fin);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.byte_present <= present;
        in_ch.end_of_message <= fin;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        item_count++;
        @(negedge clk);
    endtask

    task automatic send_message(input int len, input int mode);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            b = (mode == 0) ? 8'($urandom) : (mode == 1) ? 8'hff : 8'h00;
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            if (i == len - 1 && $urandom_range(0, 1))
                send_item(b, 1'b1, 1'b1);
            else
                send_item(b, 1'b1, 1'b0);
        end
        if (len == 0 || !in_ch.end_of_message)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int len;
        quiet = 1'b0;
        item_count = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.byte_present = 1'b0;
        in_ch.end_of_message = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        in_ch.valid <= 1'b0;
        wait (pending_words == 0);
        @(negedge clk);
        send_message(55, 1);
        send_message(56, 2);
        send_message(64, 0);

        while (item_count < 326)
        begin
            if (item_count > 260)
                quiet = 1'b1;
            case ($urandom_range(0, 5))
                0: len = $urandom_range(0, 3);
                1: len = $urandom_range(54, 66);
                2: len = $urandom_range(118, 130);
                default: len = $urandom_range(0, 40);
            endcase
            if (len > 326 - item_count)
                len = 326 - item_count;
            send_message(len, 0);
        end

        in_ch.valid <= 1'b0;
        wait (pending_words == 0);
        repeat (200) @(negedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

### sim.f
rtl/sha_pkg.sv
rtl/sha_if.sv
rtl/sha_datapath.sv
rtl/sha_control.sv
rtl/sha256_stream_hasher.sv
tb/sha256_stream_hasher_checker.sv
tb/sha256_stream_hasher_test.sv
